FILE: rtl/mdc_pkg.sv
// ----------------------------------------------------------------------------
// mdc_pkg
// Shared types, codes and constants for the microphone DC blocker, gain
// stage, block level meter and silence auto-stop.
// ----------------------------------------------------------------------------
package mdc_pkg;

  // Longest capture block in samples
  localparam int MAX_BLOCK = 256;
  localparam int BLK_W     = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
  localparam int N_W       = $clog2(MAX_BLOCK + 1);

  localparam int SUM_W  = 24;
  localparam int CNT_W  = 24;
  localparam int CFG_W  = 24;
  localparam int IDX_W  = 3;
  localparam int STEP_W = $clog2(SUM_W);

  localparam logic [SUM_W-1:0] SUM_MAX = '1;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Reset values of the configuration registers
  localparam logic [2:0]       GAIN_SHIFT_RST      = 3'd3;
  localparam logic [7:0]       LOUD_MIN_RST        = 8'd10;
  localparam logic [CNT_W-1:0] SILENCE_TIMEOUT_RST = 24'd24000;
  localparam logic [CNT_W-1:0] MIN_RECORD_RST      = 24'd16000;
  localparam logic [CNT_W-1:0] RECORD_CAPACITY_RST = 24'd480000;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_START  = 2'd1,
    CMD_STOP   = 2'd2
  } cmd_t;

  typedef enum logic [IDX_W-1:0] {
    REG_GAIN_SHIFT      = 3'd0,
    REG_LOUD_MIN        = 3'd1,
    REG_SILENCE_TIMEOUT = 3'd2,
    REG_MIN_RECORD      = 3'd3,
    REG_RECORD_CAPACITY = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [15:0] mic_sample;
    logic               block_end;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] clean_sample;
    logic [7:0]         level;
    logic               level_valid;
    logic               auto_stopped;
    logic               recording;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CLEAN,
    ST_DSTART,
    ST_DIV,
    ST_CLOSE,
    ST_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_in;
    logic exec;
    logic clean;
    logic div_start;
    logic close;
    logic load_out;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_sample;
    logic closes;
    logic div_done;
  } ctrl_sts_t;

endpackage

FILE: rtl/mic_dc_block_gain_silence_detect.sv
// ----------------------------------------------------------------------------
// mic_dc_block_gain_silence_detect: DC blocker, gain, level meter, auto-stop
// A sample passes exec and clean, a command exec only; a word that closes a block
// also passes the serial divider and the close step. One word in flight: a new
// word is taken only once the last one has been handed to the output register.
// Synchronous reset clears the block state and loads the configuration defaults.
// ----------------------------------------------------------------------------
module mic_dc_block_gain_silence_detect (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  mdc_pkg::in_word_t         in_word,
  output logic                      out_valid,
  input  logic                      out_ready,
  output mdc_pkg::out_word_t        out_word,
  input  logic                      cfg_we,
  input  logic [mdc_pkg::IDX_W-1:0] cfg_index,
  input  logic [mdc_pkg::CFG_W-1:0] cfg_data
);
  import mdc_pkg::*;

  // Command and status between the sequencer and the datapath.
  // The sequencer walks each word through:
  //   exec   - update the DC follower, or apply a start/stop command
  //   clean  - subtract DC, shift by gain, saturate, accumulate |x|,
  //            advance the quiet timer and the block count
  //   dstart - load the serial divider with the block sum and count
  //   div    - one quotient bit per cycle
  //   close  - level = min(255, sum / count / 128), capacity check,
  //            loud/quiet decision and auto-stop
  //   done   - move the finished word to the output register; the next
  //            word is taken while that register still waits on out_ready
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  mdc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Configuration writes land directly in the datapath registers; the user must
  // issue them only while no word is in flight, the block does not enforce this.
  mdc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_word   (in_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_word  (out_word)
  );

endmodule

FILE: rtl/mdc_div.sv
// ----------------------------------------------------------------------------
// mdc_div
// Restoring serial divider: one quotient bit per cycle, dividing the block
// sum by the block sample count.
// ----------------------------------------------------------------------------
module mdc_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [mdc_pkg::SUM_W-1:0] dividend,
  input  logic [mdc_pkg::N_W-1:0]   divisor,
  output logic [mdc_pkg::SUM_W-1:0] quotient,
  output logic                      done
);
  import mdc_pkg::*;

  logic [SUM_W-1:0]  quo;
  logic [N_W-1:0]    rem;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic [N_W:0]      trial;
  logic [N_W:0]      trial_sub;
  logic              fits;

  assign trial     = {rem, quo[SUM_W-1]};
  assign fits      = trial >= {1'b0, divisor};
  assign trial_sub = trial - {1'b0, divisor};
  assign done      = busy && (step == '0);
  assign quotient  = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= STEP_W'(SUM_W - 1);
    end else if (busy) begin
      // drop busy after the last quotient bit
      busy <= (step != '0);
      step <= step - STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      rem <= fits ? trial_sub[N_W-1:0] : trial[N_W-1:0];
      quo <= {quo[SUM_W-2:0], fits};
    end
  end

endmodule

FILE: rtl/mdc_datapath.sv
// ----------------------------------------------------------------------------
// mdc_datapath
// DC follower, gain and saturation, block metering, recording counters,
// configuration registers and the output word register.
// ----------------------------------------------------------------------------
module mdc_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  mdc_pkg::ctrl_cmd_t        cmd,
  output mdc_pkg::ctrl_sts_t        sts,
  input  mdc_pkg::in_word_t         in_word,
  input  logic                      cfg_we,
  input  logic [mdc_pkg::IDX_W-1:0] cfg_index,
  input  logic [mdc_pkg::CFG_W-1:0] cfg_data,
  output mdc_pkg::out_word_t        out_word
);
  import mdc_pkg::*;

  localparam logic signed [24:0] SAT_HI = 25'sd32767;
  localparam logic signed [24:0] SAT_LO = -25'sd32768;

  // Configuration
  logic [2:0]       gain_shift;
  logic [7:0]       loud_min;
  logic [CNT_W-1:0] silence_timeout;
  logic [CNT_W-1:0] min_record;
  logic [CNT_W-1:0] record_capacity;

  // Block state
  logic signed [16:0] dc_level;
  logic [SUM_W-1:0]   abs_sum;
  logic [BLK_W-1:0]   block_count;
  logic [CNT_W-1:0]   recorded_count;
  logic [CNT_W-1:0]   quiet_count;
  logic               recording_on;
  logic [7:0]         last_level;

  // Item registers
  in_word_t         in_reg;
  out_word_t        res;
  logic [N_W-1:0]   n_reg;
  logic [CNT_W:0]   rec_sum;

  // Combinational terms
  logic signed [17:0] dc_diff;
  logic signed [17:0] dc_sum;
  logic signed [24:0] shifted;
  logic signed [15:0] sat_v;
  logic [16:0]        abs_v;
  logic [SUM_W:0]     sum_wide;
  logic [SUM_W-1:0]   sum_sat;
  logic [N_W-1:0]     n_v;
  logic               closes;
  logic [SUM_W-1:0]   quotient;
  logic               div_done;
  logic [7:0]         amp;
  logic               fits;
  logic               loud;
  logic               stop_now;
  logic               is_start;
  logic               is_stop;

  mdc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (abs_sum),
    .divisor  (n_reg),
    .quotient (quotient),
    .done     (div_done)
  );

  always_comb begin
    // s - dc: before the update in the exec step, after it in the clean step
    dc_diff  = 18'(in_reg.mic_sample) - 18'(dc_level);
    dc_sum   = 18'(dc_level) + (dc_diff >>> 8);
    shifted  = 25'(dc_diff) <<< gain_shift;
    if (shifted > SAT_HI) begin
      sat_v = 16'sh7fff;
    end else if (shifted < SAT_LO) begin
      sat_v = 16'sh8000;
    end else begin
      sat_v = shifted[15:0];
    end
    abs_v    = sat_v[15] ? 17'(-(17'(sat_v))) : 17'(sat_v);
    sum_wide = {1'b0, abs_sum} + (SUM_W + 1)'(abs_v);
    sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
    n_v      = N_W'(block_count) + N_W'(1);
    closes   = in_reg.block_end || (n_v >= N_W'(MAX_BLOCK));
    amp      = (quotient[SUM_W-1:7] > (SUM_W - 7)'(255)) ? 8'hff : quotient[14:7];
    fits     = recording_on && (rec_sum <= {1'b0, record_capacity});
    loud     = amp >= loud_min;
    stop_now = fits && !loud && (rec_sum > {1'b0, min_record}) &&
               (quiet_count >= silence_timeout);
    is_start = in_reg.command == CMD_START;
    is_stop  = in_reg.command == CMD_STOP;
  end

  assign sts.is_sample = in_reg.command == CMD_SAMPLE;
  assign sts.closes    = closes;
  assign sts.div_done  = div_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_shift      <= GAIN_SHIFT_RST;
      loud_min        <= LOUD_MIN_RST;
      silence_timeout <= SILENCE_TIMEOUT_RST;
      min_record      <= MIN_RECORD_RST;
      record_capacity <= RECORD_CAPACITY_RST;
      dc_level        <= '0;
      abs_sum         <= '0;
      block_count     <= '0;
      recorded_count  <= '0;
      quiet_count     <= '0;
      recording_on    <= 1'b0;
      last_level      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GAIN_SHIFT:      gain_shift      <= cfg_data[2:0];
          REG_LOUD_MIN:        loud_min        <= cfg_data[7:0];
          REG_SILENCE_TIMEOUT: silence_timeout <= cfg_data;
          REG_MIN_RECORD:      min_record      <= cfg_data;
          REG_RECORD_CAPACITY: record_capacity <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.exec) begin
        if (sts.is_sample) begin
          dc_level <= dc_sum[16:0];
        end else if (is_start) begin
          recorded_count <= '0;
          quiet_count    <= '0;
          last_level     <= '0;
          recording_on   <= 1'b1;
        end else if (is_stop) begin
          recording_on <= 1'b0;
          last_level   <= '0;
        end
      end
      if (cmd.clean) begin
        abs_sum     <= sum_sat;
        block_count <= closes ? '0 : n_v[BLK_W-1:0];
        if (recording_on && (quiet_count != CNT_MAX)) begin
          quiet_count <= quiet_count + CNT_W'(1);
        end
      end
      if (cmd.div_start) begin
        abs_sum <= '0;
      end
      if (cmd.close) begin
        if (fits) begin
          recorded_count <= rec_sum[CNT_W-1:0];
          if (loud) begin
            quiet_count <= '0;
          end
        end
        if (stop_now) begin
          recording_on <= 1'b0;
        end
        last_level <= stop_now ? 8'd0 : amp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_reg <= in_word;
    end
    if (cmd.exec && !sts.is_sample) begin
      res.clean_sample <= '0;
      res.level        <= (is_start || is_stop) ? 8'd0 : last_level;
      res.level_valid  <= 1'b0;
      res.auto_stopped <= 1'b0;
      res.recording    <= is_start ? 1'b1 : (is_stop ? 1'b0 : recording_on);
    end
    if (cmd.clean) begin
      res.clean_sample <= sat_v;
      res.level        <= last_level;
      res.level_valid  <= 1'b0;
      res.auto_stopped <= 1'b0;
      res.recording    <= recording_on;
      n_reg            <= n_v;
    end
    if (cmd.div_start) begin
      rec_sum <= {1'b0, recorded_count} + (CNT_W + 1)'(n_reg);
    end
    if (cmd.close) begin
      res.level        <= amp;
      res.level_valid  <= 1'b1;
      res.auto_stopped <= stop_now;
      res.recording    <= recording_on && !stop_now;
    end
    if (cmd.load_out) begin
      out_word <= res;
    end
  end

endmodule

FILE: rtl/mdc_ctrl.sv
// ----------------------------------------------------------------------------
// mdc_ctrl
// Sequencer for one word at a time: exec, clean for samples only, optional block
// close with the serial divide, then hand-off to the output register.
// ----------------------------------------------------------------------------
module mdc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output mdc_pkg::ctrl_cmd_t cmd,
  input  mdc_pkg::ctrl_sts_t sts
);
  import mdc_pkg::*;

  state_t state;
  state_t state_next;

  assign in_ready = state == ST_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = sts.is_sample ? ST_CLEAN : ST_DONE;
      end
      ST_CLEAN: begin
        cmd.clean  = 1'b1;
        state_next = sts.closes ? ST_DSTART : ST_DONE;
      end
      ST_DSTART: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_next = ST_CLOSE;
        end
      end
      ST_CLOSE: begin
        cmd.close  = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

FILE: rtl/mdc_checker.sv
// ----------------------------------------------------------------------------
// mdc_checker
// Port-level checks on the top level, attached by bind.
// ----------------------------------------------------------------------------
module mdc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input mdc_pkg::out_word_t out_word
);
  import mdc_pkg::*;

  // No output word survives reset
  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // One word in flight: input closes right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a word is in flight");

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_word)))
    else $error("output word changed while stalled");

  // Auto-stop only on a block close, and it ends recording
  a_stop_consistent: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.auto_stopped) |-> (out_word.level_valid && !out_word.recording))
    else $error("auto_stopped without block close or with recording on");

endmodule

bind mic_dc_block_gain_silence_detect mdc_checker u_mdc_checker (.*);
